// File: rtl/core/dtfp_pkg.sv
// ----------------------------------------------------------------------------
// dtfp_pkg: shared definitions for the decimal text to fixed point core
// Widths, character codes, the power-of-ten table and the types used by
// the parser and the scaling divider.
// ----------------------------------------------------------------------------
package dtfp_pkg;

    // Field and state widths
    localparam int CH_W       = 8;
    localparam int VALUE_W    = 48;
    localparam int MANT_W     = 60;
    localparam int FD_W       = 5;
    localparam int DC_W       = 5;
    localparam int PLACES_MAX = 18;

    // Parameter defaults
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MAX_DIGITS_DEF = 18;

    // Character codes
    localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CH_W-1:0] CH_POINT = 8'd46;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CH_W-1:0] CH_NINE  = 8'd57;

    // Saturation limits of the magnitude
    localparam logic [VALUE_W-1:0] LIMIT_POS = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] LIMIT_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

    // Parser phase
    typedef enum logic [3:0] {
        PH_SKIP  = 4'b0001,
        PH_SIGN  = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    // Scaler sequencer state
    typedef enum logic [2:0] {
        SC_IDLE = 3'b001,
        SC_RUN  = 3'b010,
        SC_FIN  = 3'b100
    } sc_state_t;

    // Parsed number handed from parser to scaler
    typedef struct packed {
        logic [MANT_W-1:0] mantissa;
        logic [FD_W-1:0]   frac_digits;
        logic              is_negative;
        logic              overflowed;
    } num_t;

    // Ten to the power n, clamped at the largest place count
    function automatic logic [MANT_W-1:0] pow_ten(input logic [FD_W-1:0] n);
        logic [MANT_W-1:0] p;
        unique case (n)
            5'd0:    p = 60'd1;
            5'd1:    p = 60'd10;
            5'd2:    p = 60'd100;
            5'd3:    p = 60'd1000;
            5'd4:    p = 60'd10000;
            5'd5:    p = 60'd100000;
            5'd6:    p = 60'd1000000;
            5'd7:    p = 60'd10000000;
            5'd8:    p = 60'd100000000;
            5'd9:    p = 60'd1000000000;
            5'd10:   p = 60'd10000000000;
            5'd11:   p = 60'd100000000000;
            5'd12:   p = 60'd1000000000000;
            5'd13:   p = 60'd10000000000000;
            5'd14:   p = 60'd100000000000000;
            5'd15:   p = 60'd1000000000000000;
            5'd16:   p = 60'd10000000000000000;
            5'd17:   p = 60'd100000000000000000;
            default: p = 60'd1000000000000000000;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/core/dtfp_parser.sv
// ----------------------------------------------------------------------------
// dtfp_parser: character parser
// Takes one byte a beat, tracks white space, signs, digits and the point,
// and builds the decimal mantissa. A zero byte returns it to reset.
// ----------------------------------------------------------------------------
module dtfp_parser
    import dtfp_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [CH_W-1:0] ch,
    output num_t            num
);

    phase_t            phase_reg, phase_next;
    logic              neg_reg, neg_next;
    logic              point_reg, point_next;
    logic [MANT_W-1:0] mant_reg, mant_next;
    logic [FD_W-1:0]   fd_reg, fd_next;
    logic [DC_W-1:0]   dc_reg, dc_next;
    logic              ovf_reg, ovf_next;

    logic              is_digit, is_ws, is_sign, pre_num, sig, full;
    logic [3:0]        dval;
    logic [MANT_W-1:0] mant_x10;

    // Character classes
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_ws    = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign pre_num  = (phase_reg == PH_SKIP) || (phase_reg == PH_SIGN);
    assign dval     = 4'(ch - CH_ZERO);

    // Digit bookkeeping: m*10 + d by shift and add
    assign sig      = (mant_reg != '0) || (dval != 4'd0);
    assign full     = sig && (dc_reg >= DC_W'(MAX_DIGITS));
    assign mant_x10 = {mant_reg[MANT_W-4:0], 3'b000} + {mant_reg[MANT_W-2:0], 1'b0};

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        point_next = point_reg;
        mant_next  = mant_reg;
        fd_next    = fd_reg;
        dc_next    = dc_reg;
        ovf_next   = ovf_reg;
        if (take)
        begin
            priority if (ch == CH_NUL)
            begin
                phase_next = PH_SKIP;
                neg_next   = 1'b0;
                point_next = 1'b0;
                mant_next  = '0;
                fd_next    = '0;
                dc_next    = '0;
                ovf_next   = 1'b0;
            end
            else if ((phase_reg == PH_SKIP) && is_ws)
            begin
                phase_next = PH_SKIP;
            end
            else if (pre_num && is_sign)
            begin
                phase_next = PH_SIGN;
                if (ch == CH_MINUS)
                begin
                    neg_next = !neg_reg;
                end
            end
            else if (pre_num && !is_digit && (ch != CH_POINT))
            begin
                phase_next = PH_DONE;
            end
            else if (pre_num || (phase_reg == PH_DIGIT))
            begin
                phase_next = PH_DIGIT;
                priority if (is_digit)
                begin
                    if (!point_reg)
                    begin
                        if (full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            mant_next = mant_x10 + MANT_W'(dval);
                            dc_next   = dc_reg + DC_W'(sig);
                        end
                    end
                    else if (!full && (fd_reg < FD_W'(PLACES_MAX)))
                    begin
                        mant_next = mant_x10 + MANT_W'(dval);
                        dc_next   = dc_reg + DC_W'(sig);
                        fd_next   = fd_reg + 1'b1;
                    end
                end
                else if ((ch == CH_POINT) && !point_reg)
                begin
                    point_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            else
            begin
                // number already ended: ignore bytes until the zero byte
                phase_next = phase_reg;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            point_reg <= 1'b0;
            mant_reg  <= '0;
            fd_reg    <= '0;
            dc_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            point_reg <= point_next;
            mant_reg  <= mant_next;
            fd_reg    <= fd_next;
            dc_reg    <= dc_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign num.mantissa    = mant_reg;
    assign num.frac_digits = fd_reg;
    assign num.is_negative = neg_reg;
    assign num.overflowed  = ovf_reg;

endmodule

// File: rtl/core/dtfp_scaler.sv
// ----------------------------------------------------------------------------
// dtfp_scaler: fixed point scaling divider
// Computes mantissa * 2^FRAC_BITS / 10^places by restoring division, one
// quotient bit a cycle on a shared subtractor, then saturates, applies the
// sign and holds the result in the output register.
// ----------------------------------------------------------------------------
module dtfp_scaler
    import dtfp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  num_t               num,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] value,
    output logic               overflow
);

    localparam int DVD_W     = MANT_W + FRAC_BITS;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    sc_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [MANT_W-1:0]  rem_reg, rem_next;
    logic [MANT_W-1:0]  den_reg, den_next;
    logic [VALUE_W-1:0] quo_reg, quo_next;
    logic               sticky_reg, sticky_next;
    logic               neg_reg, neg_next;
    logic               ovf_reg, ovf_next;
    logic               ov_reg, ov_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic               oflag_reg, oflag_next;

    logic [MANT_W:0]    trial, diff;
    logic               qbit, out_free, sat;
    logic [VALUE_W-1:0] limit, mag;

    // Shared subtract and compare
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign qbit     = (trial >= {1'b0, den_reg});

    // Finishing: saturate and apply sign
    assign limit    = neg_reg ? LIMIT_NEG : LIMIT_POS;
    assign sat      = ovf_reg || sticky_reg || (quo_reg > limit);
    assign mag      = sat ? limit : quo_reg;
    assign out_free = !ov_reg || out_ready;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        sticky_next = sticky_reg;
        neg_next    = neg_reg;
        ovf_next    = ovf_reg;
        ov_next     = ov_reg && !out_ready;
        val_next    = val_reg;
        oflag_next  = oflag_reg;
        unique case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    state_next  = SC_RUN;
                    cnt_next    = '0;
                    dvd_next    = {num.mantissa, {FRAC_BITS{1'b0}}};
                    rem_next    = '0;
                    den_next    = pow_ten(num.frac_digits);
                    quo_next    = '0;
                    sticky_next = 1'b0;
                    neg_next    = num.is_negative;
                    ovf_next    = num.overflowed;
                end
            end
            SC_RUN:
            begin
                dvd_next    = {dvd_reg[DVD_W-2:0], 1'b0};
                rem_next    = qbit ? diff[MANT_W-1:0] : trial[MANT_W-1:0];
                quo_next    = {quo_reg[VALUE_W-2:0], qbit};
                sticky_next = sticky_reg || quo_reg[VALUE_W-1];
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = SC_FIN;
                end
            end
            SC_FIN:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    val_next   = neg_reg ? (VALUE_W'(0) - mag) : mag;
                    oflag_next = sat;
                    state_next = SC_IDLE;
                end
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        sticky_reg <= sticky_next;
        neg_reg    <= neg_next;
        ovf_reg    <= ovf_next;
        val_reg    <= val_next;
        oflag_reg  <= oflag_next;
    end

    assign busy      = (state_reg != SC_IDLE);
    assign out_valid = ov_reg;
    assign value     = val_reg;
    assign overflow  = oflag_reg;

endmodule

// File: rtl/core/decimal_text_to_fixed_point_core.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_core: ASCII decimal to signed Q32.16
// Parses a zero-terminated decimal string into saturated signed fixed point.
// ----------------------------------------------------------------------------
// A nonzero byte is taken whenever in_ready is high, so text streams at one byte a cycle while the divider is idle.
// The zero byte that ends a string starts the scaling divider: a restoring
// division on one shared subtractor, one quotient bit a cycle, runs through
// every bit of the dividend and is followed by a finishing state that
// saturates and signs the result; in_ready stays low while the divider runs
// and finishes. Should the previous result still sit unclaimed in the output
// register, the block holds in that finishing state until out_ready frees it.
// The result is truncated toward zero; overflow marks saturation or a dropped
// integer digit.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_core
    import dtfp_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CH_W-1:0]           ch,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] value,
    output logic                      overflow
);

    logic               take, busy;
    num_t               num;
    logic [VALUE_W-1:0] value_u;

    // Input beat and end of string
    assign in_ready = !busy;
    assign take     = in_valid && in_ready;

    dtfp_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .ch    (ch),
        .num   (num)
    );

    dtfp_scaler #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (take && (ch == CH_NUL)),
        .num       (num),
        .busy      (busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value_u),
        .overflow  (overflow)
    );

    assign value = signed'(value_u);

endmodule

// File: rtl/core/dtfp_checker.sv
// ----------------------------------------------------------------------------
// dtfp_checker: port-level checks for the decimal text to fixed point core
// Watches the handshakes and the result over time and reports by $error.
// ----------------------------------------------------------------------------
module dtfp_checker
    import dtfp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [CH_W-1:0]    ch,
    input logic               out_valid,
    input logic               out_ready,
    input logic [VALUE_W-1:0] value,
    input logic               overflow
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(overflow))
        else $error("result changed while stalled");

    // End of string makes the block busy
    a_busy_after_nul: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (ch == CH_NUL) |=> !in_ready)
        else $error("ready after end of string");

    // A new result appears only at the end of a busy stretch
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without division");

    // Saturated results sit on a limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> (value == LIMIT_POS) || (value == LIMIT_NEG))
        else $error("overflow flagged off the limits");

endmodule

bind decimal_text_to_fixed_point_core dtfp_checker u_dtfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .overflow  (overflow)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: decimal text to fixed point core
// Streams zero-terminated decimal strings into the core one byte per beat and
// checks every Q32.16 result and its overflow flag against a parser model
// kept here. Both handshakes idle at random, and the receiver once holds off
// for a long stretch so that the core backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

    import dtfp_pkg::*;

    localparam int TEXT_BYTES = 1800;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 120;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [CH_W-1:0]           ch        = CH_NUL;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;

    int unsigned bytes_sent = 0;
    logic [CH_W-1:0] text_bytes[$];

    // ------------------------------------------------------------------------
    // Parser model and store of numbers still to come out
    // ------------------------------------------------------------------------
    class fixed_point_scoreboard;

        typedef struct {
            logic [VALUE_W-1:0] value;
            logic               overflow;
        } number_t;

        number_t         expected_numbers[$];
        phase_t          phase;
        bit              negative;
        bit              point_seen;
        longint unsigned mantissa;
        int unsigned     places;
        int unsigned     sig_digits;
        bit              int_dropped;

        int unsigned mismatches = 0;
        int unsigned numbers_checked = 0;
        int unsigned saturated_seen = 0;
        int unsigned negatives_seen = 0;

        function new();
            clear_number();
        endfunction

        function void clear_number();
            phase       = PH_SKIP;
            negative    = 1'b0;
            point_seen  = 1'b0;
            mantissa    = 0;
            places      = 0;
            sig_digits  = 0;
            int_dropped = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_numbers.size();
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Leading zeros are free; digits beyond the limit are dropped
        function void take_digit(input int unsigned d);
            bit significant;
            significant = (mantissa != 0) || (d != 0);
            if (!point_seen) begin
                if (significant && sig_digits >= MAX_DIGITS_DEF) begin
                    int_dropped = 1'b1;
                    return;
                end
            end
            else begin
                if (places >= PLACES_MAX)
                    return;
                if (significant && sig_digits >= MAX_DIGITS_DEF)
                    return;
                places++;
            end
            mantissa = mantissa * 10 + d;
            if (significant)
                sig_digits++;
        endfunction

        // Scale mantissa / 10^places into Q32.16, truncate, saturate, sign
        function void finish_number();
            longint unsigned limit;
            longint unsigned mag;
            longint unsigned den;
            longint unsigned quot;
            longint unsigned rem;
            longint unsigned frac;
            bit              sat;
            number_t         num;
            limit = negative ? (64'd1 << 47) : (64'd1 << 47) - 1;
            mag   = 0;
            sat   = int_dropped;
            if (!sat) begin
                den = 1;
                for (int i = 0; i < places && i < PLACES_MAX; i++)
                    den = den * 10;
                quot = mantissa / den;
                rem  = mantissa % den;
                frac = 0;
                for (int b = 0; b < FRAC_BITS_DEF; b++) begin
                    rem  = rem << 1;
                    frac = frac << 1;
                    if (rem >= den) begin
                        rem  = rem - den;
                        frac = frac | 1;
                    end
                end
                if (quot > ((64'd1 << 47) >> FRAC_BITS_DEF))
                    sat = 1'b1;
                else begin
                    mag = (quot << FRAC_BITS_DEF) | frac;
                    if (mag > limit)
                        sat = 1'b1;
                end
            end
            if (sat)
                mag = limit;
            num.value = mag[VALUE_W-1:0];
            if (negative)
                num.value = -num.value;
            num.overflow = sat;
            expected_numbers.push_back(num);
        endfunction

        // One accepted input beat
        function void note_byte(input logic [CH_W-1:0] c);
            bit is_digit;
            bit is_space;
            bit early;
            is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
            is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
            early    = (phase == PH_SKIP) || (phase == PH_SIGN);
            if (c == CH_NUL) begin
                finish_number();
                clear_number();
                return;
            end
            if (phase == PH_SKIP && is_space)
                return;
            if (early && (c == CH_PLUS || c == CH_MINUS)) begin
                phase = PH_SIGN;
                if (c == CH_MINUS)
                    negative = !negative;
                return;
            end
            if (early) begin
                if (is_digit || c == CH_POINT)
                    phase = PH_DIGIT;
                else begin
                    phase = PH_DONE;
                    return;
                end
            end
            if (phase == PH_DIGIT) begin
                if (is_digit)
                    take_digit(32'(c - CH_ZERO));
                else if (c == CH_POINT && !point_seen)
                    point_seen = 1'b1;
                else
                    phase = PH_DONE;
            end
        endfunction

        // One accepted result beat against the oldest expectation
        task check_number(input logic [VALUE_W-1:0] got_value, input logic got_overflow);
            number_t num;
            if (expected_numbers.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d overflow %0b",
                                          $signed(got_value), got_overflow));
                return;
            end
            num = expected_numbers.pop_front();
            numbers_checked++;
            if (num.overflow)
                saturated_seen++;
            if (num.value[VALUE_W-1])
                negatives_seen++;
            if (got_value !== num.value)
                report_mismatch($sformatf("value %0d, expected %0d",
                                          $signed(got_value), $signed(num.value)));
            if (got_overflow !== num.overflow)
                report_mismatch($sformatf("overflow %0b, expected %0b",
                                          got_overflow, num.overflow));
        endtask

    endclass

    fixed_point_scoreboard sb = new();

    decimal_text_to_fixed_point_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .overflow  (overflow)
    );

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Give up long after the slowest correct run would have finished
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Sample both handshakes at the edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_byte(ch);
            if (out_valid && out_ready)
                sb.check_number(value, overflow);
        end
    end

    // Receiver: random stalls, a quiet stretch, and one long hold-off
    initial
    begin
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge clk);
            if (!held && sb.numbers_checked == 30) begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (sb.numbers_checked >= 80 && sb.numbers_checked < 140)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 6);
        end
    end

    // One input beat; returns at the edge that takes it
    task automatic send_byte(input logic [CH_W-1:0] b);
        bit quiet;
        quiet = (bytes_sent >= 700 && bytes_sent < 1100);
        while (!quiet && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
        send_byte(CH_NUL);
    endtask

    function automatic logic [CH_W-1:0] any_digit();
        return CH_W'(CH_ZERO + $urandom_range(9));
    endfunction

    // Random string: mostly well-formed numbers, some noise and broken tails
    function automatic void compose_number();
        int unsigned int_len;
        int unsigned frac_len;
        text_bytes.delete();
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(8))
                text_bytes.push_back(CH_W'($urandom_range(1, 255)));
        end
        else begin
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(1, 3))
                    text_bytes.push_back($urandom_range(3) == 0 ? CH_SPACE
                                         : CH_W'($urandom_range(CH_TAB, CH_CR)));
            if ($urandom_range(99) < 45)
                repeat ($urandom_range(1, 3))
                    text_bytes.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
            if ($urandom_range(19) == 0)
                text_bytes.push_back(CH_SPACE);
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 4))
                    text_bytes.push_back(CH_ZERO);
            int_len = ($urandom_range(7) == 0) ? $urandom_range(8, 22) : $urandom_range(6);
            repeat (int_len)
                text_bytes.push_back(any_digit());
            if ($urandom_range(99) < 65) begin
                text_bytes.push_back(CH_POINT);
                if ($urandom_range(5) == 0)
                    repeat ($urandom_range(1, 6))
                        text_bytes.push_back(CH_ZERO);
                frac_len = ($urandom_range(7) == 0) ? $urandom_range(8, 24)
                                                    : $urandom_range(6);
                repeat (frac_len)
                    text_bytes.push_back(any_digit());
            end
            // trailing text that should be ignored
            if ($urandom_range(99) < 25) begin
                case ($urandom_range(3))
                    0: text_bytes.push_back(CH_POINT);
                    1: text_bytes.push_back(CH_MINUS);
                    2: text_bytes.push_back(CH_SPACE);
                    default: text_bytes.push_back(CH_W'($urandom_range(1, 255)));
                endcase
                repeat ($urandom_range(3))
                    text_bytes.push_back(CH_W'($urandom_range(1, 255)));
            end
        end
        text_bytes.push_back(CH_NUL);
    endfunction

    // Stimulus and end of run
    initial
    begin
        string edge_texts[8];
        edge_texts[0] = "2147483647.9999847";
        edge_texts[1] = "2147483648";
        edge_texts[2] = "-2147483648";
        edge_texts[3] = "-2147483648.00002";
        edge_texts[4] = "0.0000152587890625";
        edge_texts[5] = "999999999999999999";
        edge_texts[6] = "-0.0000000000000000000001";
        edge_texts[7] = "12345678901234567.89";

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: white space, sign run, leading zeros, second point ends
        send_byte(CH_CR);
        send_byte(CH_TAB);
        send_text("-+-00.50.9");
        // all bits set, a string with no digits, negative zero, lone point
        send_byte(8'hFF);
        send_byte(CH_NUL);
        send_text("-0");
        send_text(".");
        send_text("");
        // white space after a sign ends the number
        send_text("+ 5");

        // Random strings, with the odd value right at a boundary
        while (bytes_sent < TEXT_BYTES) begin
            if ($urandom_range(99) < 4)
                send_text(edge_texts[$urandom_range(7)]);
            else begin
                compose_number();
                foreach (text_bytes[i])
                    send_byte(text_bytes[i]);
            end
        end
        in_valid <= 1'b0;

        // Drain, then allow for a late extra result
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d numbers never came out", sb.pending()));

        $display("Run covered %0d text bytes giving %0d numbers: %0d negative, %0d saturated.",
                 bytes_sent, sb.numbers_checked, sb.negatives_seen, sb.saturated_seen);
        $display("Mismatches found: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
